// ----- src/fpc_pkg.sv -----
package fpc_pkg;

    localparam int LANES       = 4;
    localparam int SAMPLE_BITS = 24;
    localparam int MAG_W       = SAMPLE_BITS - 1;
    localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W       = $clog2(LANES + 1);
    localparam int ADDR_W      = 5;
    localparam int MUL_W       = 26;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int LOG_W       = 21;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_SLOPE     = 3'd1;
    localparam logic [2:0] REG_ATTACK    = 3'd2;
    localparam logic [2:0] REG_RELEASE   = 3'd3;
    localparam logic [2:0] REG_MAKEUP    = 3'd4;
    localparam logic [2:0] REG_ACTIVE    = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_0;
        logic signed [SAMPLE_BITS-1:0] sample_1;
        logic signed [SAMPLE_BITS-1:0] sample_2;
        logic signed [SAMPLE_BITS-1:0] sample_3;
        logic                          block_end;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_0;
        logic signed [SAMPLE_BITS-1:0] out_1;
        logic signed [SAMPLE_BITS-1:0] out_2;
        logic signed [SAMPLE_BITS-1:0] out_3;
        logic [22:0]                   gain_applied;
        logic                          block_end_out;
    } result_t;

    typedef struct packed {
        logic [22:0] threshold_lin;
        logic [15:0] slope;
        logic [23:0] attack_coeff;
        logic [23:0] release_coeff;
        logic [22:0] makeup_gain;
        logic [2:0]  active_channels;
    } cfg_t;

    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_op_t;

endpackage

// ----- src/feed_forward_peak_compressor.sv -----
// Feed-forward peak compressor, one frame per request, single shared multiplier.
// Frames are taken only while idle, once the previous result is registered. The
// sequencer steps peak scan, envelope, log, gain and lane scaling, with envelope,
// gain and lane on the multiplier; reduction is skipped when envelope <= threshold.
// Reset: asynchronous, active low; registers to defaults, envelope to zero.
module feed_forward_peak_compressor (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fpc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       frame_valid,
    output logic                       frame_ready,
    input  fpc_pkg::frame_t            frame,
    output logic                       result_valid,
    input  logic                       result_ready,
    output fpc_pkg::result_t           result
);
    import fpc_pkg::*;

    cfg_t                     cfg;
    mul_op_t                  mul_op;
    logic signed [PROD_W-1:0] prod;

    fpc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpc_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .prod (prod)
    );

    fpc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mul_op       (mul_op),
        .prod         (prod)
    );

endmodule

// ----- src/fpc_regs.sv -----
module fpc_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fpc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output fpc_pkg::cfg_t             cfg
);
    import fpc_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_lin   <= 23'd838861;
            cfg_reg.slope           <= 16'd49152;
            cfg_reg.attack_coeff    <= 24'd16742300;
            cfg_reg.release_coeff   <= 24'd16773721;
            cfg_reg.makeup_gain     <= 23'd65536;
            cfg_reg.active_channels <= 3'd2;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_THRESHOLD: cfg_reg.threshold_lin   <= pwdata[22:0];
                REG_SLOPE:     cfg_reg.slope           <= pwdata[15:0];
                REG_ATTACK:    cfg_reg.attack_coeff    <= pwdata[23:0];
                REG_RELEASE:   cfg_reg.release_coeff   <= pwdata[23:0];
                REG_MAKEUP:    cfg_reg.makeup_gain     <= pwdata[22:0];
                REG_ACTIVE:    cfg_reg.active_channels <= pwdata[2:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_THRESHOLD: prdata = 32'(cfg_reg.threshold_lin);
            REG_SLOPE:     prdata = 32'(cfg_reg.slope);
            REG_ATTACK:    prdata = 32'(cfg_reg.attack_coeff);
            REG_RELEASE:   prdata = 32'(cfg_reg.release_coeff);
            REG_MAKEUP:    prdata = 32'(cfg_reg.makeup_gain);
            REG_ACTIVE:    prdata = 32'(cfg_reg.active_channels);
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// ----- src/fpc_mul.sv -----
module fpc_mul (
    input  logic                              clk,
    input  fpc_pkg::mul_op_t                  op,
    output logic signed [fpc_pkg::PROD_W-1:0] prod
);
    import fpc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // shared multiplier, product registered
    always_ff @(posedge clk)
    begin
        prod_reg <= op.a * op.b;
    end

    assign prod = prod_reg;

endmodule

// ----- src/fpc_core.sv -----
module fpc_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fpc_pkg::cfg_t                     cfg,
    input  logic                              frame_valid,
    output logic                              frame_ready,
    input  fpc_pkg::frame_t                   frame,
    output logic                              result_valid,
    input  logic                              result_ready,
    output fpc_pkg::result_t                  result,
    output fpc_pkg::mul_op_t                  mul_op,
    input  logic signed [fpc_pkg::PROD_W-1:0] prod
);
    import fpc_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_PEAK  = 13'b0000000000010,
        S_ENV_A = 13'b0000000000100,
        S_ENV_B = 13'b0000000001000,
        S_ENV_C = 13'b0000000010000,
        S_LOG_E = 13'b0000000100000,
        S_LOG_T = 13'b0000001000000,
        S_RED_A = 13'b0000010000000,
        S_RED_B = 13'b0000100000000,
        S_TOT_A = 13'b0001000000000,
        S_TOT_B = 13'b0010000000000,
        S_LANE  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    localparam logic [MAG_W-1:0]  MAXMAG  = {MAG_W{1'b1}};
    localparam logic [24:0]       ONE_Q24 = 25'h1000000;
    localparam logic [16:0]       UNITY   = 17'h10000;
    localparam logic signed [PROD_W-1:0] SMAX = PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SMIN = -SMAX - PROD_W'(1);

    state_t                  state_reg, state_next;
    frame_t                  frame_reg;
    result_t                 result_reg;
    logic                    res_valid_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [MAG_W-1:0]        peak_reg;
    logic [MAG_W-1:0]        env_reg;
    logic [46:0]             acc_reg;
    logic [LOG_W-1:0]        le_reg;
    logic [LOG_W-1:0]        over_reg;
    logic [16:0]             gain_reg;
    logic [22:0]             total_reg;
    logic signed [SAMPLE_BITS-1:0] lane_reg [LANES];

    logic signed [SAMPLE_BITS-1:0] samp [LANES];
    logic signed [SAMPLE_BITS-1:0] cur;
    logic [SAMPLE_BITS-1:0]  neg;
    logic [MAG_W-1:0]        mag;
    logic [CNT_W-1:0]        act;
    logic [CNT_W-1:0]        wr_idx;
    logic [23:0]             coef;
    logic [24:0]             coef_inv;
    logic [MAG_W-1:0]        thr;
    logic [MAG_W-1:0]        log_in;
    logic [LOG_W-1:0]        log_out;
    logic [47:0]             env_sum;
    logic [37:0]             red_sum;
    logic [21:0]             red;
    logic [40:0]             tot_sum;
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] q;
    logic signed [SAMPLE_BITS-1:0] lane_val;
    logic                    out_free;

    function automatic logic [LOG_W-1:0] mlog2(input logic [MAG_W-1:0] x);
        logic [4:0]       k;
        logic [MAG_W-1:0] norm;
        k = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (x[b])
                k = 5'(b);
        end
        norm = x << (5'(MAG_W - 1) - k);
        return {k, norm[MAG_W-2 -: 16]};
    endfunction

    function automatic logic [16:0] mexp2neg(input logic [21:0] r);
        logic [5:0]  i;
        logic [15:0] f;
        logic [17:0] num;
        i   = r[21:16];
        f   = r[15:0];
        num = 18'd131072 - 18'(f);
        if (f == 16'd0)
            return (i >= 6'd32) ? 17'd0 : (UNITY >> i[4:0]);
        else if (i >= 6'd31)
            return 17'd0;
        else
            return 17'(num >> (i[4:0] + 5'd1));
    endfunction

    assign samp[0] = frame_reg.sample_0;
    assign samp[1] = frame_reg.sample_1;
    assign samp[2] = frame_reg.sample_2;
    assign samp[3] = frame_reg.sample_3;

    assign act      = (cfg.active_channels > CNT_W'(LANES)) ? CNT_W'(LANES)
                                                            : CNT_W'(cfg.active_channels);
    assign cur      = samp[cnt_reg[LANE_W-1:0]];
    assign neg      = -cur;
    assign mag      = !cur[SAMPLE_BITS-1] ? cur[MAG_W-1:0]
                    : (neg[SAMPLE_BITS-1] ? MAXMAG : neg[MAG_W-1:0]);
    assign coef     = (peak_reg > env_reg) ? cfg.attack_coeff : cfg.release_coeff;
    assign coef_inv = ONE_Q24 - 25'(coef);
    assign thr      = (cfg.threshold_lin == '0) ? MAG_W'(1) : cfg.threshold_lin;
    assign log_in   = (state_reg == S_LOG_T) ? thr : env_reg;
    assign log_out  = mlog2(log_in);
    assign env_sum  = 48'(acc_reg) + 48'(prod[46:0]) + 48'h800000;
    assign red_sum  = prod[37:0] + 38'd32768;
    assign red      = red_sum[37:16];
    assign tot_sum  = 41'(prod[39:0]) + 41'd32768;
    assign rnd      = prod + PROD_W'(32768);
    assign q        = rnd >>> 16;
    assign wr_idx   = cnt_reg - CNT_W'(1);
    assign lane_val = (wr_idx >= act) ? '0
                    : (q > SMAX) ? SMAX[SAMPLE_BITS-1:0]
                    : (q < SMIN) ? SMIN[SAMPLE_BITS-1:0]
                    : q[SAMPLE_BITS-1:0];
    assign out_free = !res_valid_reg || result_ready;

    assign frame_ready  = (state_reg == S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        mul_op.a = '0;
        mul_op.b = '0;
        unique case (state_reg)
            S_ENV_A:
            begin
                mul_op.a = MUL_W'(coef);
                mul_op.b = MUL_W'(env_reg);
            end
            S_ENV_B:
            begin
                mul_op.a = MUL_W'(coef_inv);
                mul_op.b = MUL_W'(peak_reg);
            end
            S_RED_A:
            begin
                mul_op.a = MUL_W'(over_reg);
                mul_op.b = MUL_W'(cfg.slope);
            end
            S_TOT_A:
            begin
                mul_op.a = MUL_W'(gain_reg);
                mul_op.b = MUL_W'(cfg.makeup_gain);
            end
            S_LANE:
            begin
                mul_op.a = MUL_W'(cur);
                mul_op.b = MUL_W'(total_reg);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (frame_valid) state_next = S_PEAK;
            S_PEAK:  if (cnt_reg == CNT_W'(LANES - 1)) state_next = S_ENV_A;
            S_ENV_A: state_next = S_ENV_B;
            S_ENV_B: state_next = S_ENV_C;
            S_ENV_C: state_next = S_LOG_E;
            S_LOG_E: state_next = (env_reg > thr) ? S_LOG_T : S_TOT_A;
            S_LOG_T: state_next = S_RED_A;
            S_RED_A: state_next = S_RED_B;
            S_RED_B: state_next = S_TOT_A;
            S_TOT_A: state_next = S_TOT_B;
            S_TOT_B: state_next = S_LANE;
            S_LANE:  if (cnt_reg == CNT_W'(LANES)) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            env_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                S_PEAK:  cnt_reg <= (cnt_reg == CNT_W'(LANES - 1)) ? '0 : cnt_reg + CNT_W'(1);
                S_LANE:  cnt_reg <= (cnt_reg == CNT_W'(LANES)) ? '0 : cnt_reg + CNT_W'(1);
                default: cnt_reg <= '0;
            endcase

            if (state_reg == S_ENV_C)
                env_reg <= env_sum[46:24];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                frame_reg <= frame;
                peak_reg  <= '0;
            end
            S_PEAK:
            begin
                if (cnt_reg < act && mag > peak_reg)
                    peak_reg <= mag;
            end
            S_ENV_B: acc_reg <= prod[46:0];
            S_LOG_E:
            begin
                le_reg   <= log_out;
                gain_reg <= UNITY;
            end
            S_LOG_T: over_reg <= (le_reg > log_out) ? le_reg - log_out : '0;
            S_RED_B: gain_reg <= mexp2neg(red);
            S_TOT_B: total_reg <= tot_sum[38:16];
            S_LANE:
            begin
                if (cnt_reg != '0)
                    lane_reg[wr_idx[LANE_W-1:0]] <= lane_val;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    result_reg.out_0         <= lane_reg[0];
                    result_reg.out_1         <= lane_reg[1];
                    result_reg.out_2         <= lane_reg[2];
                    result_reg.out_3         <= lane_reg[3];
                    result_reg.gain_applied  <= total_reg;
                    result_reg.block_end_out <= frame_reg.block_end;
                end
            end
            default: ;
        endcase
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready |=> state_reg == S_PEAK)
        else $error("accepted request did not start peak scan");

    a_env_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_ENV_C |=> $stable(env_reg))
        else $error("envelope changed outside update step");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion step");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LANES))
        else $error("lane counter out of range");

endmodule

// ----- tb/fpc_checker.sv -----
`timescale 1ns / 100ps

module fpc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fpc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic [31:0]                prdata,
    input  logic                       pready,
    input  logic                       frame_valid,
    input  logic                       frame_ready,
    input  fpc_pkg::frame_t            frame,
    input  logic                       result_valid,
    input  logic                       result_ready,
    input  fpc_pkg::result_t           result,
    output int                         fail_count,
    output int                         frames_in_flight
);

    import fpc_pkg::*;

    localparam logic [63:0]        MAG_MAX = (64'd1 << MAG_W) - 1;
    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 1;

    cfg_t          cfg;
    logic [22:0]   envelope;
    result_t       pending_results[$];

    // Mitchell log2, Q.16
    function automatic logic [63:0] log2_q16(input logic [63:0] x);
        int k;
        k = 0;
        while (k < 63 && (x >> (k + 1)) != 0)
            k++;
        return (64'(k) << 16) + (((x - (64'd1 << k)) << 16) >> k);
    endfunction

    // Mitchell 2^-x, x in Q.16, result Q1.16
    function automatic logic [63:0] exp2_neg_q16(input logic [63:0] red);
        logic [63:0] i;
        logic [63:0] f;
        i = red >> 16;
        f = red & 64'hFFFF;
        if (f == 0)
            return (i >= 32) ? 64'd0 : (64'd65536 >> i);
        if (i + 1 >= 32)
            return 64'd0;
        return (64'd131072 - f) >> (i + 1);
    endfunction

    function automatic result_t compress_frame(input frame_t f);
        logic signed [SAMPLE_BITS-1:0] lane_in [LANES];
        logic signed [SAMPLE_BITS-1:0] lane_out [LANES];
        logic signed [63:0]            s;
        logic signed [63:0]            q;
        logic signed [63:0]            total_s;
        logic [63:0]                   mag;
        logic [63:0]                   peak;
        logic [63:0]                   coeff;
        logic [63:0]                   env;
        logic [63:0]                   thr;
        logic [63:0]                   le;
        logic [63:0]                   lt;
        logic [63:0]                   over;
        logic [63:0]                   red;
        logic [63:0]                   gain;
        logic [63:0]                   total;
        int                            act;
        result_t                       r;

        lane_in[0] = f.sample_0;
        lane_in[1] = f.sample_1;
        lane_in[2] = f.sample_2;
        lane_in[3] = f.sample_3;
        act = int'(cfg.active_channels);
        if (act > LANES)
            act = LANES;

        peak = '0;
        for (int l = 0; l < LANES; l++) begin
            if (l < act) begin
                s   = lane_in[l];
                mag = (s < 0) ? -s : s;
                if (mag > MAG_MAX)
                    mag = MAG_MAX;
                if (mag > peak)
                    peak = mag;
            end
        end

        coeff    = (peak > envelope) ? cfg.attack_coeff : cfg.release_coeff;
        env      = (coeff * envelope + ((64'd1 << 24) - coeff) * peak + (64'd1 << 23)) >> 24;
        envelope = env[MAG_W-1:0];

        thr  = (cfg.threshold_lin == 0) ? 64'd1 : 64'(cfg.threshold_lin);
        gain = 64'd65536;
        if (env > thr) begin
            le   = log2_q16(env);
            lt   = log2_q16(thr);
            over = (le > lt) ? le - lt : 64'd0;
            red  = (over * cfg.slope + 64'd32768) >> 16;
            gain = exp2_neg_q16(red);
        end
        total   = ((gain * cfg.makeup_gain + 64'd32768) >> 16) & 64'h7F_FFFF;
        total_s = total;

        for (int l = 0; l < LANES; l++) begin
            lane_out[l] = '0;
            if (l < act) begin
                s = lane_in[l];
                q = (s * total_s + 64'sd32768) >>> 16;
                if (q > OUT_MAX)
                    q = OUT_MAX;
                if (q < OUT_MIN)
                    q = OUT_MIN;
                lane_out[l] = q[SAMPLE_BITS-1:0];
            end
        end

        r.out_0         = lane_out[0];
        r.out_1         = lane_out[1];
        r.out_2         = lane_out[2];
        r.out_3         = lane_out[3];
        r.gain_applied  = total[22:0];
        r.block_end_out = f.block_end;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [23:0] want_v,
                               input logic [23:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        result_t     want;
        logic [31:0] reg_val;

        if (!rst_n) begin
            cfg.threshold_lin   = 23'd838861;
            cfg.slope           = 16'd49152;
            cfg.attack_coeff    = 24'd16742300;
            cfg.release_coeff   = 24'd16773721;
            cfg.makeup_gain     = 23'd65536;
            cfg.active_channels = 3'd2;
            envelope            = '0;
            pending_results.delete();
            frames_in_flight   <= 0;
        end
        else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[ADDR_W-1:2])
                        REG_THRESHOLD: cfg.threshold_lin   = pwdata[22:0];
                        REG_SLOPE:     cfg.slope           = pwdata[15:0];
                        REG_ATTACK:    cfg.attack_coeff    = pwdata[23:0];
                        REG_RELEASE:   cfg.release_coeff   = pwdata[23:0];
                        REG_MAKEUP:    cfg.makeup_gain     = pwdata[22:0];
                        REG_ACTIVE:    cfg.active_channels = pwdata[2:0];
                        default: ;
                    endcase
                end
                else begin
                    case (paddr[ADDR_W-1:2])
                        REG_THRESHOLD: reg_val = 32'(cfg.threshold_lin);
                        REG_SLOPE:     reg_val = 32'(cfg.slope);
                        REG_ATTACK:    reg_val = 32'(cfg.attack_coeff);
                        REG_RELEASE:   reg_val = 32'(cfg.release_coeff);
                        REG_MAKEUP:    reg_val = 32'(cfg.makeup_gain);
                        default:       reg_val = 32'(cfg.active_channels);
                    endcase
                    if (prdata !== reg_val) begin
                        $display("%0t: register %0d expected %h, got %h",
                                 $time, paddr[ADDR_W-1:2], reg_val, prdata);
                        fail_count++;
                    end
                end
            end

            if (result_valid && result_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with no request pending, got %h", $time, result);
                    fail_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    check_field("out_0", want.out_0, result.out_0);
                    check_field("out_1", want.out_1, result.out_1);
                    check_field("out_2", want.out_2, result.out_2);
                    check_field("out_3", want.out_3, result.out_3);
                    check_field("gain_applied", 24'(want.gain_applied),
                                24'(result.gain_applied));
                    check_field("block_end_out", 24'(want.block_end_out),
                                24'(result.block_end_out));
                end
            end

            if (frame_valid && frame_ready)
                pending_results.push_back(compress_frame(frame));

            frames_in_flight <= pending_results.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    import fpc_pkg::*;

    localparam int         STALL_LIMIT = 2000;
    localparam logic [2:0] REG_SPARE   = 3'd6;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [31:0]       pwdata       = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              frame_valid  = 1'b0;
    logic              frame_ready;
    frame_t            frame        = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    result_t           result;

    int   fail_count;
    int   frames_in_flight;
    int   stalled_cycles;
    int   run_left = 0;
    int   level    = 0;
    bit   calm     = 1'b0;
    cfg_t settings [6];

    feed_forward_peak_compressor uut (.*);

    fpc_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic frame_t frame_of(input int a, input int b, input int c,
                                        input int d, input bit be);
        frame_t f;
        f.sample_0  = 24'(a);
        f.sample_1  = 24'(b);
        f.sample_2  = 24'(c);
        f.sample_3  = 24'(d);
        f.block_end = be;
        return f;
    endfunction

    // quiet, moderate and loud runs, with the odd raw-bit frame
    function automatic frame_t random_frame(input int lvl);
        int     amp;
        int     v [LANES];
        frame_t f;
        amp = (lvl < 3) ? 4096 : (lvl < 6) ? (1 << 20) : 8388607;
        for (int l = 0; l < LANES; l++)
        begin
            if (lvl == 9)
                v[l] = $urandom;
            else if ($urandom_range(0, 15) == 0)
                v[l] = $urandom_range(0, 1) ? 8388607 : -8388608;
            else
                v[l] = int'($urandom_range(0, 2 * amp)) - amp;
        end
        f = frame_of(v[0], v[1], v[2], v[3], $urandom_range(0, 7) == 0);
        return f;
    endfunction

    function automatic cfg_t setting_of(input int thr, input int slp, input int att,
                                        input int rel, input int mkp, input int act);
        cfg_t c;
        c.threshold_lin   = 23'(thr);
        c.slope           = 16'(slp);
        c.attack_coeff    = 24'(att);
        c.release_coeff   = 24'(rel);
        c.makeup_gain     = 23'(mkp);
        c.active_channels = 3'(act);
        return c;
    endfunction

    task automatic reg_access(input logic is_write, input logic [2:0] idx,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle(input int extra);
        frame_valid <= 1'b0;
        @(posedge clk);
        while (frames_in_flight != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        wait_idle(25);
        reg_access(1'b1, REG_THRESHOLD, 32'(c.threshold_lin));
        reg_access(1'b1, REG_SLOPE,     32'(c.slope));
        reg_access(1'b1, REG_ATTACK,    32'(c.attack_coeff));
        reg_access(1'b1, REG_RELEASE,   32'(c.release_coeff));
        reg_access(1'b1, REG_MAKEUP,    32'(c.makeup_gain));
        reg_access(1'b1, REG_ACTIVE,    32'(c.active_channels));
        for (int i = 0; i <= int'(REG_ACTIVE); i++)
            reg_access(1'b0, 3'(i), '0);
    endtask

    task automatic push_frame(input frame_t f);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            frame_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        frame       <= f;
        frame_valid <= 1'b1;
        @(posedge clk);
        while (!frame_ready)
            @(posedge clk);
    endtask

    task automatic random_frames(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (run_left == 0)
            begin
                level    = $urandom_range(0, 9);
                run_left = $urandom_range(1, 24);
            end
            run_left--;
            push_frame(random_frame(level));
        end
    endtask

    initial
    begin : sink
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((frame_valid && frame_ready) || (result_valid && result_ready) || psel)
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        settings[0] = setting_of(838861, 62259, 0, 1 << 23, 65536, 4);
        settings[1] = setting_of(8389, 32768, 24'hFF_FFFF, 0, 6553600, 1);
        settings[2] = setting_of(0, 65535, 1 << 12, 24'hFF_FFFF, 100, 0);
        settings[3] = setting_of(23'h7F_FFFF, 0, 1 << 20, 1 << 23, 23'h7F_FFFF, 7);
        settings[4] = setting_of($urandom_range(0, 23'h7F_FFFF), $urandom_range(0, 65535),
                                 $urandom_range(0, 24'hFF_FFFF),
                                 $urandom_range(0, 24'hFF_FFFF),
                                 $urandom_range(65536, 6553600), $urandom_range(0, 7));
        settings[5] = setting_of(1 << 20, 49152, 1 << 22, 1 << 23, 131072, 3);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: two lanes live, upper lanes must be ignored
        push_frame(frame_of(1000, -1000, 8388607, -8388608, 1'b1));
        push_frame(frame_of(-8388608, 8388607, -8388608, -8388608, 1'b0));
        push_frame(frame_of(0, 0, 0, 0, 1'b0));
        push_frame(frame_of(0, -1, 0, 8388607, 1'b1));
        random_frames(40);

        // instant attack so the envelope follows the peak
        apply_settings(settings[0]);
        push_frame(frame_of(0, 0, 0, 0, 1'b0));
        push_frame(frame_of(8388607, 8388607, 8388607, 8388607, 1'b1));
        push_frame(frame_of(-8388608, -8388608, -8388608, -8388608, 1'b0));
        push_frame(frame_of(8388607, -8388608, -1, 1, 1'b0));
        push_frame(frame_of(5, -5, 5, 7340032, 1'b0));
        push_frame(frame_of(838861, -838861, 0, 0, 1'b0));
        push_frame(frame_of(838862, 0, 0, 0, 1'b1));
        push_frame(frame_of(0, 0, 0, 0, 1'b0));
        push_frame(frame_of(0, 0, 0, 0, 1'b0));
        push_frame(frame_of(0, 0, -8388608, 0, 1'b0));
        push_frame(frame_of(1, -1, 1, -1, 1'b0));
        push_frame(frame_of(4194304, -4194304, 4194304, -4194304, 1'b0));
        push_frame(frame_of(8388607, 8388607, -8388608, 8388607, 1'b1));
        random_frames(65);

        for (int p = 1; p < 6; p++)
        begin
            apply_settings(settings[p]);
            if (p == 2)
                reg_access(1'b1, REG_SPARE, 32'hFFFF_FFFF);
            if (p == 5)
                calm = 1'b1;
            random_frames(75);
        end

        wait_idle(40);
        if (fail_count == 0 && frames_in_flight == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- feed_forward_peak_compressor.f -----
src/fpc_pkg.sv
src/fpc_regs.sv
src/fpc_mul.sv
src/fpc_core.sv
src/feed_forward_peak_compressor.sv
tb/fpc_checker.sv
tb/tb_top.sv
